[rtl/decimating_fir_q15_top_assert.svh]
// Assertion macros for the decimating Q15 FIR filter checker.
`ifndef DECIMATING_FIR_Q15_TOP_ASSERT_SVH
`define DECIMATING_FIR_Q15_TOP_ASSERT_SVH

// Clocked property, held off while reset is high.
`define DFIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define DFIR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dfir_pkg.sv]
// Shared constants, types and coefficient ROM of the decimating Q15 FIR filter.
package dfir_pkg;

   localparam int DefTaps    = 19;
   localparam int RomTaps    = 19;
   localparam int TapIdxW    = 6;
   localparam int SampleW    = 16;
   localparam int ValueW     = 21;
   localparam int FactorW    = 5;
   localparam int CountW     = 4;
   localparam int ProdW      = 2 * SampleW;
   localparam int ShiftW     = ProdW - 15;
   localparam int MaxFactor  = 16;
   localparam int DefFactor  = 10;

   typedef enum logic [1:0] {
      StIdle,
      StRun,
      StDrain,
      StDone
   } state_type;

   typedef struct packed {
      logic               issue;
      logic               clear;
      logic [TapIdxW-1:0] tap;
   } mac_ctl_type;

   function automatic logic signed [SampleW-1:0] coef_rom(input logic [TapIdxW-1:0] tap);
      logic signed [SampleW-1:0] c;
      case (tap)
         6'd0:    c = 16'sd2430;
         6'd1:    c = 16'sd1072;
         6'd2:    c = 16'sd1266;
         6'd3:    c = 16'sd1456;
         6'd4:    c = 16'sd1632;
         6'd5:    c = 16'sd1786;
         6'd6:    c = 16'sd1914;
         6'd7:    c = 16'sd2010;
         6'd8:    c = 16'sd2069;
         6'd9:    c = 16'sd2088;
         6'd10:   c = 16'sd2069;
         6'd11:   c = 16'sd2010;
         6'd12:   c = 16'sd1914;
         6'd13:   c = 16'sd1786;
         6'd14:   c = 16'sd1632;
         6'd15:   c = 16'sd1456;
         6'd16:   c = 16'sd1266;
         6'd17:   c = 16'sd1072;
         6'd18:   c = 16'sd2430;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Floor shift by 15, then clamp to the Q15 range.
   function automatic logic signed [SampleW-1:0] sat_q15(input logic signed [ProdW-1:0] p);
      logic signed [ShiftW-1:0]  s;
      logic signed [SampleW-1:0] r;
      s = ShiftW'(p >>> 15);
      if (s > ShiftW'(32767)) begin
         r = 16'sh7fff;
      end else if (s < -ShiftW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = SampleW'(s);
      end
      return r;
   endfunction

endpackage

[rtl/dfir_if.sv]
// Valid/ready channel interfaces for sample beats and result beats.
interface dfir_req_if
   import dfir_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [SampleW-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dfir_rsp_if
   import dfir_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [ValueW-1:0] filtered_value;

   modport source (output valid, output filtered_value, input ready);
   modport sink   (input valid, input filtered_value, output ready);
endinterface

[rtl/decimating_fir_q15_top.sv]
// Decimating Q15 FIR filter top level.
// A new sample beat is taken only once the last one has been swept through all taps
// and any due result is loaded into the result register, as set by the
// single read port of the delay-line RAM feeding the one shared multiply-accumulate.
// Reset is synchronous: control clears, the delay line reads as zero through
// per-entry valid bits, and the decimation factor returns to 10.
module decimating_fir_q15_top
   import dfir_pkg::*;
#(
   parameter int TAPS = DefTaps
) (
   input  logic               clock,
   input  logic               reset,
   dfir_req_if.sink           req_bus,
   dfir_rsp_if.source         rsp_bus,
   input  logic               csr_wr_en,
   input  logic [FactorW-1:0] csr_wr_data
);

   localparam int AddrW = $clog2(TAPS);

   logic                      ram_wr_en;
   logic [AddrW-1:0]          ram_wr_addr;
   logic                      ram_rd_en;
   logic [AddrW-1:0]          ram_rd_addr;
   logic signed [SampleW-1:0] ram_rd_data;
   mac_ctl_type               mac_ctl;
   logic                      mac_busy;
   logic signed [ValueW-1:0]  mac_acc;

   dfir_ctrl #(
      .TAPS  (TAPS),
      .AddrW (AddrW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .mac_ctl     (mac_ctl),
      .mac_busy    (mac_busy),
      .mac_acc     (mac_acc),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_value   (rsp_bus.filtered_value)
   );

   dfir_ram #(
      .TAPS  (TAPS),
      .AddrW (AddrW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_bus.sample),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dfir_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .rd_data (ram_rd_data),
      .acc     (mac_acc),
      .busy    (mac_busy)
   );

endmodule

[rtl/dfir_ram.sv]
// Delay-line memory: one write port, one registered read port, per-entry valid bits.
module dfir_ram
   import dfir_pkg::*;
#(
   parameter int TAPS  = DefTaps,
   parameter int AddrW = $clog2(TAPS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [AddrW-1:0]          wr_addr,
   input  logic signed [SampleW-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AddrW-1:0]          rd_addr,
   output logic signed [SampleW-1:0] rd_data
);

   logic signed [SampleW-1:0] mem [TAPS];
   logic [TAPS-1:0]           valid_ff;
   logic signed [SampleW-1:0] rd_data_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/dfir_mac.sv]
// Shared multiply, saturate and accumulate pipeline over the taps.
module dfir_mac
   import dfir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctl_type               ctl,
   input  logic signed [SampleW-1:0] rd_data,
   output logic signed [ValueW-1:0]  acc,
   output logic                      busy
);

   logic                      v1_ff;
   logic [TapIdxW-1:0]        tap1_ff;
   logic                      v2_ff;
   logic signed [ProdW-1:0]   prod_ff;
   logic signed [ProdW-1:0]   prod_in;
   logic signed [ValueW-1:0]  acc_ff;
   logic signed [ValueW-1:0]  acc_in;

   always_comb begin
      prod_in = coef_rom(tap1_ff) * rd_data;
      acc_in  = acc_ff + ValueW'(sat_q15(prod_ff));
   end

   always_ff @(posedge clock) begin
      tap1_ff <= ctl.tap;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         if (ctl.clear) begin
            acc_ff <= '0;
         end else if (v2_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign acc  = acc_ff;
   assign busy = v1_ff | v2_ff;

endmodule

[rtl/dfir_ctrl.sv]
// Sequencer: sample write, tap read sweep, decimation count and result register.
module dfir_ctrl
   import dfir_pkg::*;
#(
   parameter int TAPS  = DefTaps,
   parameter int AddrW = $clog2(TAPS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     csr_wr_en,
   input  logic [FactorW-1:0]       csr_wr_data,
   output logic                     ram_wr_en,
   output logic [AddrW-1:0]         ram_wr_addr,
   output logic                     ram_rd_en,
   output logic [AddrW-1:0]         ram_rd_addr,
   output mac_ctl_type              mac_ctl,
   input  logic                     mac_busy,
   input  logic signed [ValueW-1:0] mac_acc,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ValueW-1:0] rsp_value
);

   localparam logic [AddrW-1:0] LastIdx = AddrW'(TAPS - 1);

   state_type                state_ff, state_in;
   logic [AddrW-1:0]         wp_ff, wp_in;
   logic [AddrW-1:0]         addr_ff, addr_in;
   logic [AddrW-1:0]         k_ff, k_in;
   logic [CountW-1:0]        cnt_ff, cnt_in;
   logic                     emit_ff, emit_in;
   logic [FactorW-1:0]       factor_ff;
   logic                     rsp_valid_ff;
   logic signed [ValueW-1:0] rsp_value_ff;
   logic                     accept;
   logic                     load_rsp;
   logic [FactorW-1:0]       factor_eff;
   logic [FactorW-1:0]       cnt_inc;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               state_in = StRun;
            end
         end
         StRun: begin
            if (k_ff == LastIdx) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (!mac_busy) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (!emit_ff || !rsp_valid_ff || rsp_ready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready    = 1'b0;
      ram_rd_en    = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         StIdle:  req_ready = 1'b1;
         StRun:   ram_rd_en = 1'b1;
         StDrain: ;
         StDone:  load_rsp  = emit_ff && (!rsp_valid_ff || rsp_ready);
         default: ;
      endcase
      accept        = req_valid && req_ready;
      ram_wr_en     = accept;
      ram_wr_addr   = wp_ff;
      ram_rd_addr   = addr_ff;
      mac_ctl.issue = ram_rd_en;
      mac_ctl.clear = accept;
      mac_ctl.tap   = TapIdxW'(k_ff);
   end

   always_comb begin
      if (factor_ff == '0) begin
         factor_eff = FactorW'(1);
      end else if (factor_ff > FactorW'(MaxFactor)) begin
         factor_eff = FactorW'(MaxFactor);
      end else begin
         factor_eff = factor_ff;
      end
      cnt_inc = FactorW'(cnt_ff) + FactorW'(1);

      wp_in   = wp_ff;
      addr_in = addr_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      emit_in = emit_ff;
      if (accept) begin
         wp_in   = (wp_ff == LastIdx) ? '0 : wp_ff + AddrW'(1);
         addr_in = wp_ff;
         k_in    = '0;
         if (cnt_inc >= factor_eff) begin
            emit_in = 1'b1;
            cnt_in  = '0;
         end else begin
            emit_in = 1'b0;
            cnt_in  = CountW'(cnt_inc);
         end
      end else if (ram_rd_en) begin
         addr_in = (addr_ff == '0) ? LastIdx : addr_ff - AddrW'(1);
         k_in    = k_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff <= mac_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         wp_ff        <= '0;
         addr_ff      <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         emit_ff      <= 1'b0;
         factor_ff    <= FactorW'(DefFactor);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         addr_ff  <= addr_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         if (csr_wr_en) begin
            factor_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[rtl/dfir_checker.sv]
// Port-level checker for the decimating Q15 FIR filter, bound to the top level.
`include "decimating_fir_q15_top_assert.svh"

module dfir_checker
   import dfir_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [ValueW-1:0] rsp_filtered_value
);

   `DFIR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped while stalled")
   `DFIR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_filtered_value), "stalled result beat changed")
   `DFIR_ASSERT(a_busy_after_take, clock, reset, req_valid && req_ready |=> !req_ready, "sample beat taken while a sweep runs")
   `DFIR_ASSERT(a_no_early_result, clock, reset, req_valid && req_ready |=> !$rose(rsp_valid), "result beat shown before its sweep")
   `DFIR_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result beat shown out of reset")

endmodule

bind decimating_fir_q15_top dfir_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_filtered_value (rsp_bus.filtered_value)
);
